/* rtl/core/mls_pkg.sv */
// Shared types and constants for the mailbox line splitter.
// Used by the core modules other than the channel interfaces, and by the checker.
`timescale 1ns / 1ps
`default_nettype none

package mls_pkg;

  // Byte values the line scanner looks for, and its limits and reset value.
  localparam logic [7:0] LF_BYTE     = 8'd10;
  localparam logic [7:0] COLON_BYTE  = 8'h3A;
  localparam logic [7:0] HYPHEN_BYTE = 8'h2D;
  localparam logic [7:0] SPACE_BYTE  = 8'h20;
  localparam logic [7:0] POS_MAX     = 8'd255;
  localparam logic [7:0] COLON_MIN_RESET = 8'd4;
  localparam logic [2:0] FROM_LEN    = 3'd5;

  // Action codes of a result.
  localparam logic [2:0] ACT_NONE         = 3'd0;
  localparam logic [2:0] ACT_HOLD_FROM    = 3'd1;
  localparam logic [2:0] ACT_HOLD_TAG     = 3'd2;
  localparam logic [2:0] ACT_WRITE_LINE   = 3'd3;
  localparam logic [2:0] ACT_WRITE_HEADER = 3'd4;
  localparam logic [2:0] ACT_FLUSH_TAGS0  = 3'd5;
  localparam logic [2:0] ACT_FLUSH_TAGS1  = 3'd6;
  localparam logic [2:0] ACT_FLUSH_TAGS2  = 3'd7;

  localparam logic [1:0] SLOT_NONE = 2'd0;

  typedef enum logic [3:0] {
    SPLIT_IDLE     = 4'd0,
    SPLIT_TAG1     = 4'd1,
    SPLIT_TAG2     = 4'd2,
    SPLIT_TAG3     = 4'd3,
    SPLIT_WAIT_TAG = 4'd4,
    SPLIT_BODY     = 4'd5,
    SPLIT_NEW_TAG1 = 4'd6,
    SPLIT_NEW_TAG2 = 4'd7,
    SPLIT_NEW_TAG3 = 4'd8,
    SPLIT_NEW_WAIT = 4'd9
  } split_state_t;

  typedef enum logic [1:0] {
    TAG_SCANNING = 2'd0,
    TAG_ACCEPTED = 2'd1,
    TAG_REJECTED = 2'd2
  } tag_status_t;

  // What the line scanner knows about the line that is ending.
  typedef struct packed {
    logic is_from;
    logic is_tag;
  } line_flags_t;

  typedef struct packed {
    logic [2:0] line_action;
    logic [1:0] tag_slot;
    logic       line_is_from;
    logic       line_is_tag;
    logic [3:0] next_split_state;
  } line_result_t;

  // Byte of the "From " prefix at a given match position.
  function automatic logic [7:0] from_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h46; // F
      3'd1:    ch = 8'h72; // r
      3'd2:    ch = 8'h6F; // o
      3'd3:    ch = 8'h6D; // m
      default: ch = SPACE_BYTE;
    endcase
    return ch;
  endfunction

  function automatic logic is_letter(input logic [7:0] ch);
    return ((ch >= 8'h41) && (ch <= 8'h5A)) || ((ch >= 8'h61) && (ch <= 8'h7A));
  endfunction

endpackage

`default_nettype wire

/* rtl/core/mls_in_if.sv */
// Input channel of the mailbox line splitter: one text byte per transfer.
// Depends on nothing but the valid/ready handshake convention.
`timescale 1ns / 1ps
`default_nettype none

interface mls_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

`default_nettype wire

/* rtl/core/mls_out_if.sv */
// Result channel of the mailbox line splitter: one action per ended line.
// Depends on nothing but the valid/ready handshake convention.
`timescale 1ns / 1ps
`default_nettype none

interface mls_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] line_action;
  logic [1:0] tag_slot;
  logic       line_is_from;
  logic       line_is_tag;
  logic [3:0] next_split_state;

  modport source (output valid, output line_action, output tag_slot, output line_is_from,
                  output line_is_tag, output next_split_state, input ready);
  modport sink   (input valid, input line_action, input tag_slot, input line_is_from,
                  input line_is_tag, input next_split_state, output ready);
endinterface

`default_nettype wire

/* rtl/core/mls_line_scan.sv */
// Per-line scanner: tracks the "From " prefix match and the header tag check.
// Depends on mls_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mls_line_scan (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step,
  input  wire logic [7:0]           text_byte,
  input  wire logic [7:0]           colon_min,
  output mls_pkg::line_flags_t      flags
);

  logic [7:0]           char_pos_r,  char_pos_nxt;
  logic [2:0]           from_cnt_r,  from_cnt_nxt;
  logic                 from_mis_r,  from_mis_nxt;
  mls_pkg::tag_status_t tag_st_r,    tag_st_nxt;
  logic                 is_lf;

  assign is_lf = (text_byte == mls_pkg::LF_BYTE);

  // Flags describe the line as it stands before the line feed is taken.
  assign flags.is_from = (from_cnt_r == mls_pkg::FROM_LEN);
  assign flags.is_tag  = (tag_st_r == mls_pkg::TAG_ACCEPTED);

  always_comb begin
    char_pos_nxt = char_pos_r;
    from_cnt_nxt = from_cnt_r;
    from_mis_nxt = from_mis_r;
    tag_st_nxt   = tag_st_r;
    if (step) begin
      if (is_lf) begin
        char_pos_nxt = '0;
        from_cnt_nxt = '0;
        from_mis_nxt = 1'b0;
        tag_st_nxt   = mls_pkg::TAG_SCANNING;
      end else begin
        if (!from_mis_r && (from_cnt_r < mls_pkg::FROM_LEN)) begin
          if (text_byte == mls_pkg::from_char(from_cnt_r)) begin
            from_cnt_nxt = from_cnt_r + 3'd1;
          end else begin
            from_mis_nxt = 1'b1;
          end
        end
        if (tag_st_r == mls_pkg::TAG_SCANNING) begin
          if ((text_byte == mls_pkg::COLON_BYTE) && (char_pos_r < colon_min)) begin
            tag_st_nxt = mls_pkg::TAG_REJECTED;
          end else if (text_byte == mls_pkg::SPACE_BYTE) begin
            tag_st_nxt = mls_pkg::TAG_ACCEPTED;
          end else if (!(mls_pkg::is_letter(text_byte) ||
                         (text_byte == mls_pkg::COLON_BYTE) ||
                         (text_byte == mls_pkg::HYPHEN_BYTE))) begin
            tag_st_nxt = mls_pkg::TAG_REJECTED;
          end
        end
        if (char_pos_r != mls_pkg::POS_MAX) begin
          char_pos_nxt = char_pos_r + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_pos_r <= '0;
      from_cnt_r <= '0;
      from_mis_r <= 1'b0;
      tag_st_r   <= mls_pkg::TAG_SCANNING;
    end else begin
      char_pos_r <= char_pos_nxt;
      from_cnt_r <= from_cnt_nxt;
      from_mis_r <= from_mis_nxt;
      tag_st_r   <= tag_st_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/mls_split_fsm.sv */
// Message-splitting state machine, stepped once per ended line.
// Depends on mls_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mls_split_fsm (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  line_end,
  input  wire mls_pkg::line_flags_t  flags,
  output mls_pkg::line_result_t      result
);

  mls_pkg::split_state_t state_r, state_nxt;
  logic [3:0]            st_bits;
  logic [3:0]            st_minus5;
  logic [3:0]            st_minus1;
  logic [2:0]            action;
  logic [1:0]            slot;

  assign st_bits   = state_r;
  assign st_minus5 = st_bits - 4'd5;
  assign st_minus1 = st_bits - 4'd1;

  always_comb begin
    action    = mls_pkg::ACT_NONE;
    slot      = mls_pkg::SLOT_NONE;
    state_nxt = state_r;
    case (state_r)
      mls_pkg::SPLIT_IDLE: begin
        if (flags.is_from) begin
          action    = mls_pkg::ACT_HOLD_FROM;
          state_nxt = mls_pkg::SPLIT_TAG1;
        end
      end
      mls_pkg::SPLIT_TAG1, mls_pkg::SPLIT_TAG2, mls_pkg::SPLIT_TAG3: begin
        if (flags.is_tag) begin
          action    = mls_pkg::ACT_HOLD_TAG;
          slot      = st_bits[1:0];
          state_nxt = mls_pkg::split_state_t'(st_bits + 4'd1);
        end else begin
          state_nxt = mls_pkg::SPLIT_IDLE;
        end
      end
      mls_pkg::SPLIT_WAIT_TAG, mls_pkg::SPLIT_NEW_WAIT: begin
        if (flags.is_tag) begin
          action    = mls_pkg::ACT_WRITE_HEADER;
          state_nxt = mls_pkg::SPLIT_BODY;
        end
      end
      mls_pkg::SPLIT_BODY: begin
        if (flags.is_from) begin
          action    = mls_pkg::ACT_HOLD_FROM;
          state_nxt = mls_pkg::SPLIT_NEW_TAG1;
        end else begin
          action    = mls_pkg::ACT_WRITE_LINE;
        end
      end
      mls_pkg::SPLIT_NEW_TAG1, mls_pkg::SPLIT_NEW_TAG2, mls_pkg::SPLIT_NEW_TAG3: begin
        if (flags.is_tag) begin
          action    = mls_pkg::ACT_HOLD_TAG;
          slot      = st_minus5[1:0];
          state_nxt = mls_pkg::split_state_t'(st_bits + 4'd1);
        end else begin
          // A new message ended its header early: flush what is held.
          action    = st_minus1[2:0];
          state_nxt = mls_pkg::SPLIT_BODY;
        end
      end
      default: begin
        state_nxt = mls_pkg::SPLIT_IDLE;
      end
    endcase
  end

  assign result.line_action      = action;
  assign result.tag_slot         = slot;
  assign result.line_is_from     = flags.is_from;
  assign result.line_is_tag      = flags.is_tag;
  assign result.next_split_state = state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mls_pkg::SPLIT_IDLE;
    end else if (line_end) begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/mailbox_line_splitter_unit.sv */
// Mailbox line splitter: takes mailbox text one byte per transfer and gives one
// result per line feed. Throughput is one byte per clock while no line feed is
// held back: a byte is captured in an input register, from which the line
// scanner and the split state machine consume it; a line feed then loads the
// result register. Other bytes give no result. A line feed waits in the input
// register only while the result register holds a result not yet transferred.
// colon_min_index resets to 4 and is written through cfg_we/cfg_wdata; the user
// must write it only while the block is idle; the block does not enforce this.
// Depends on mls_pkg, mls_in_if, mls_out_if, mls_line_scan and mls_split_fsm.
`timescale 1ns / 1ps
`default_nettype none

module mailbox_line_splitter_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  mls_in_if.sink          in_ch,
  mls_out_if.source       out_ch,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata
);

  logic                  in_valid_r;
  logic [7:0]            in_byte_r;
  logic [7:0]            colon_min_r;
  logic                  out_valid_r;
  mls_pkg::line_result_t out_data_r;

  logic                  in_is_lf;
  logic                  advance;
  logic                  line_end;
  mls_pkg::line_flags_t  flags;
  mls_pkg::line_result_t result;

  assign in_is_lf = (in_byte_r == mls_pkg::LF_BYTE);
  // A line feed moves on only when the result register can take it.
  assign advance  = in_valid_r && (!in_is_lf || !out_valid_r || out_ch.ready);
  assign line_end = advance && in_is_lf;
  assign in_ch.ready = !in_valid_r || advance;

  mls_line_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .text_byte (in_byte_r),
    .colon_min (colon_min_r),
    .flags     (flags)
  );

  mls_split_fsm u_fsm (
    .clk      (clk),
    .rst_n    (rst_n),
    .line_end (line_end),
    .flags    (flags),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colon_min_r <= mls_pkg::COLON_MIN_RESET;
    end else if (cfg_we) begin
      colon_min_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.text_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (line_end) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (line_end) begin
      out_data_r <= result;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.line_action      = out_data_r.line_action;
  assign out_ch.tag_slot         = out_data_r.tag_slot;
  assign out_ch.line_is_from     = out_data_r.line_is_from;
  assign out_ch.line_is_tag      = out_data_r.line_is_tag;
  assign out_ch.next_split_state = out_data_r.next_split_state;

endmodule

`default_nettype wire

/* rtl/core/mls_checker.sv */
// Port-level checks for the mailbox line splitter, bound to the top level.
// Depends on mls_pkg and mailbox_line_splitter_unit.
`timescale 1ns / 1ps
`default_nettype none

module mls_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] line_action,
  input wire logic [1:0] tag_slot,
  input wire logic       line_is_from,
  input wire logic       line_is_tag,
  input wire logic [3:0] next_split_state
);

  // A stalled result must stay put until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(line_action) &&
      $stable(tag_slot) && $stable(next_split_state)))
    else $error("result changed while stalled");

  // A tag slot is named exactly when a tag line is held.
  a_slot_action: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((line_action == mls_pkg::ACT_HOLD_TAG) == (tag_slot != 2'd0)))
    else $error("tag slot does not match action");

  // Holding a From line requires a line with the From prefix.
  a_hold_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (line_action == mls_pkg::ACT_HOLD_FROM)) |-> line_is_from)
    else $error("From line held without From prefix");

  // Writing a header always comes from a tag line and enters the body.
  a_header_body: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (line_action == mls_pkg::ACT_WRITE_HEADER)) |->
      (line_is_tag && (next_split_state == mls_pkg::SPLIT_BODY)))
    else $error("header write without tag or body entry");

endmodule

bind mailbox_line_splitter_unit mls_checker u_mls_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .line_action      (out_ch.line_action),
  .tag_slot         (out_ch.tag_slot),
  .line_is_from     (out_ch.line_is_from),
  .line_is_tag      (out_ch.line_is_tag),
  .next_split_state (out_ch.next_split_state)
);

`default_nettype wire

/* sim/mailbox_line_splitter_unit_test.sv */
// Self-checking testbench for mailbox_line_splitter_unit: a table of mailbox lines,
// then random messages and noise under several colon_min_index settings.
// Depends on mls_pkg, mls_in_if, mls_out_if and the unit itself.
`timescale 1ns / 1ps

module mailbox_line_splitter_unit_test;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  mls_in_if  in_ch ();
  mls_out_if out_ch ();

  mailbox_line_splitter_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  typedef struct {
    string                 text;
    logic [7:0]            fill;
    int                    fill_cnt;
    bit                    typed;
    mls_pkg::line_result_t want;
  } line_row_t;

  // Each row is one line: its text, then fill_cnt copies of fill, then a line feed.
  line_row_t directed_rows [29] = '{
    '{"", 8'h00, 0, 1'b1,
      '{mls_pkg::ACT_NONE, mls_pkg::SLOT_NONE, 1'b0, 1'b0, mls_pkg::SPLIT_IDLE}},
    '{"From a@b.c Mon", 8'h00, 0, 1'b1,
      '{mls_pkg::ACT_HOLD_FROM, mls_pkg::SLOT_NONE, 1'b1, 1'b1, mls_pkg::SPLIT_TAG1}},
    '{"Subject: hello", 8'h00, 0, 1'b0, '0},
    '{"Re: x", 8'h00, 0, 1'b0, '0},
    '{"From x", 8'h00, 0, 1'b0, '0},
    '{"X-To: a", 8'h00, 0, 1'b0, '0},
    '{"Date:x y", 8'h00, 0, 1'b0, '0},
    '{"Re-ply:: z", 8'h00, 0, 1'b0, '0},
    '{"Rex: no", 8'h00, 0, 1'b0, '0},
    '{"", 8'h00, 1, 1'b0, '0},
    '{"Status: RO", 8'h00, 0, 1'b0, '0},
    '{"Body text here", 8'h00, 0, 1'b0, '0},
    '{"Frog leg", 8'h00, 0, 1'b0, '0},
    '{"From y", 8'h00, 0, 1'b0, '0},
    '{"", 8'h00, 0, 1'b0, '0},
    '{"From z", 8'h00, 0, 1'b0, '0},
    '{"Abcd: q", 8'h00, 0, 1'b0, '0},
    '{"nospace", 8'h00, 0, 1'b0, '0},
    '{"From w", 8'h00, 0, 1'b0, '0},
    '{"Aaaa: 1", 8'h00, 0, 1'b0, '0},
    '{"Bbbb: 2", 8'h00, 0, 1'b0, '0},
    '{"", 8'hFF, 3, 1'b0, '0},
    '{"From v", 8'h00, 0, 1'b0, '0},
    '{"Ccc-Dd: 1", 8'h00, 0, 1'b0, '0},
    '{"Eeee: 2", 8'h00, 0, 1'b0, '0},
    '{"Gggg: 3", 8'h00, 0, 1'b0, '0},
    '{"x", 8'h09, 1, 1'b0, '0},
    '{"Zz-Top: end", 8'h00, 0, 1'b0, '0},
    '{"Long", 8'h61, 300, 1'b0, '0}
  };

  // "From " spelled out byte by byte.
  logic [7:0] from_text [5] = '{8'h46, 8'h72, 8'h6F, 8'h6D, mls_pkg::SPACE_BYTE};

  // Mirror of the splitter state.
  mls_pkg::split_state_t split_q = mls_pkg::SPLIT_IDLE;
  logic [7:0]            line_pos = '0;
  logic [2:0]            from_hits = '0;
  logic                  from_broken = 1'b0;
  mls_pkg::tag_status_t  tag_scan = mls_pkg::TAG_SCANNING;
  logic [7:0]            colon_min = mls_pkg::COLON_MIN_RESET;

  mls_pkg::line_result_t expected_lines [$];
  logic [7:0]            text_stream [$];

  int          n_fail = 0;
  int          n_bytes = 0;
  int          n_lines = 0;
  int          n_settings = 1;
  logic [7:0]  actions_seen = '0;
  bit          no_idle = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic step_splitter(input logic [7:0] c, output bit has_line,
                               output mls_pkg::line_result_t r);
    bit                    is_from;
    bit                    is_tag;
    mls_pkg::split_state_t nxt;
    logic [3:0]            rel;
    has_line = 1'b0;
    r = '0;
    if (c != mls_pkg::LF_BYTE) begin
      if (!from_broken && from_hits < mls_pkg::FROM_LEN) begin
        if (c == from_text[from_hits]) from_hits++;
        else from_broken = 1'b1;
      end
      if (tag_scan == mls_pkg::TAG_SCANNING) begin
        if (c == mls_pkg::COLON_BYTE && line_pos < colon_min)
          tag_scan = mls_pkg::TAG_REJECTED;
        else if (c == mls_pkg::SPACE_BYTE) tag_scan = mls_pkg::TAG_ACCEPTED;
        else if (!((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
                   c == mls_pkg::COLON_BYTE || c == mls_pkg::HYPHEN_BYTE))
          tag_scan = mls_pkg::TAG_REJECTED;
      end
      if (line_pos != mls_pkg::POS_MAX) line_pos++;
      return;
    end
    is_from = (from_hits == mls_pkg::FROM_LEN);
    is_tag = (tag_scan == mls_pkg::TAG_ACCEPTED);
    nxt = split_q;
    r.line_action = mls_pkg::ACT_NONE;
    r.tag_slot = mls_pkg::SLOT_NONE;
    case (split_q)
      mls_pkg::SPLIT_IDLE: begin
        if (is_from) begin
          r.line_action = mls_pkg::ACT_HOLD_FROM;
          nxt = mls_pkg::SPLIT_TAG1;
        end
      end
      mls_pkg::SPLIT_TAG1, mls_pkg::SPLIT_TAG2, mls_pkg::SPLIT_TAG3: begin
        if (is_tag) begin
          r.line_action = mls_pkg::ACT_HOLD_TAG;
          r.tag_slot = split_q[1:0];
          nxt = mls_pkg::split_state_t'(split_q + 4'd1);
        end else begin
          nxt = mls_pkg::SPLIT_IDLE;
        end
      end
      mls_pkg::SPLIT_WAIT_TAG, mls_pkg::SPLIT_NEW_WAIT: begin
        if (is_tag) begin
          r.line_action = mls_pkg::ACT_WRITE_HEADER;
          nxt = mls_pkg::SPLIT_BODY;
        end
      end
      mls_pkg::SPLIT_BODY: begin
        if (is_from) begin
          r.line_action = mls_pkg::ACT_HOLD_FROM;
          nxt = mls_pkg::SPLIT_NEW_TAG1;
        end else begin
          r.line_action = mls_pkg::ACT_WRITE_LINE;
        end
      end
      mls_pkg::SPLIT_NEW_TAG1, mls_pkg::SPLIT_NEW_TAG2, mls_pkg::SPLIT_NEW_TAG3: begin
        if (is_tag) begin
          rel = split_q - 4'd5;
          r.line_action = mls_pkg::ACT_HOLD_TAG;
          r.tag_slot = rel[1:0];
          nxt = mls_pkg::split_state_t'(split_q + 4'd1);
        end else begin
          // The held From line goes out with however many tags were collected.
          case (split_q)
            mls_pkg::SPLIT_NEW_TAG1: r.line_action = mls_pkg::ACT_FLUSH_TAGS0;
            mls_pkg::SPLIT_NEW_TAG2: r.line_action = mls_pkg::ACT_FLUSH_TAGS1;
            default:                 r.line_action = mls_pkg::ACT_FLUSH_TAGS2;
          endcase
          nxt = mls_pkg::SPLIT_BODY;
        end
      end
      default: nxt = mls_pkg::SPLIT_IDLE;
    endcase
    r.line_is_from = is_from;
    r.line_is_tag = is_tag;
    r.next_split_state = nxt;
    split_q = nxt;
    line_pos = '0;
    from_hits = '0;
    from_broken = 1'b0;
    tag_scan = mls_pkg::TAG_SCANNING;
    has_line = 1'b1;
  endtask

  task automatic send_byte(input logic [7:0] b, input bit use_table,
                           input mls_pkg::line_result_t table_want);
    int unsigned           gap;
    bit                    has_line;
    mls_pkg::line_result_t r;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.text_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_bytes++;
    step_splitter(b, has_line, r);
    if (has_line) expected_lines.push_back(use_table ? table_want : r);
  endtask

  task automatic check_line();
    mls_pkg::line_result_t want;
    if (expected_lines.size() == 0) begin
      $error("result transfer with no line pending: action %0d", out_ch.line_action);
      n_fail++;
      return;
    end
    want = expected_lines.pop_front();
    n_lines++;
    actions_seen[out_ch.line_action] = 1'b1;
    if (out_ch.line_action !== want.line_action) begin
      $error("line_action: expected %0d, got %0d", want.line_action, out_ch.line_action);
      n_fail++;
    end
    if (out_ch.tag_slot !== want.tag_slot) begin
      $error("tag_slot: expected %0d, got %0d", want.tag_slot, out_ch.tag_slot);
      n_fail++;
    end
    if (out_ch.line_is_from !== want.line_is_from) begin
      $error("line_is_from: expected %0d, got %0d", want.line_is_from, out_ch.line_is_from);
      n_fail++;
    end
    if (out_ch.line_is_tag !== want.line_is_tag) begin
      $error("line_is_tag: expected %0d, got %0d", want.line_is_tag, out_ch.line_is_tag);
      n_fail++;
    end
    if (out_ch.next_split_state !== want.next_split_state) begin
      $error("next_split_state: expected %0d, got %0d", want.next_split_state,
             out_ch.next_split_state);
      n_fail++;
    end
  endtask

  // Result side: random stalls of ready, one assignment per edge.
  initial begin
    int unsigned stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) check_line();
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  task automatic drain_lines();
    while (expected_lines.size() != 0) @(posedge clk);
    // Bytes that end no line may still sit in the input register.
    repeat (4) @(posedge clk);
  endtask

  task automatic set_colon_min(input logic [7:0] v);
    drain_lines();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    colon_min = v;
    n_settings++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) text_stream.push_back(s[i]);
  endtask

  task automatic add_printable(input int n);
    repeat (n) text_stream.push_back(8'($urandom_range(8'h20, 8'h7E)));
  endtask

  task automatic add_letter();
    int unsigned r;
    r = $urandom_range(0, 51);
    text_stream.push_back(r < 26 ? 8'(8'h41 + r) : 8'(8'h61 + r - 26));
  endtask

  task automatic add_from_line();
    add_text("From ");
    add_printable($urandom_range(0, 20));
    text_stream.push_back(mls_pkg::LF_BYTE);
  endtask

  task automatic add_tag_line();
    int unsigned r;
    repeat ($urandom_range(1, 12)) begin
      r = $urandom_range(0, 99);
      if (r < 70) add_letter();
      else if (r < 85) text_stream.push_back(mls_pkg::HYPHEN_BYTE);
      else text_stream.push_back(mls_pkg::COLON_BYTE);
    end
    if ($urandom_range(0, 99) < 85) text_stream.push_back(mls_pkg::SPACE_BYTE);
    else text_stream.push_back(8'($urandom_range(0, 255)));
    add_printable($urandom_range(0, 15));
    text_stream.push_back(mls_pkg::LF_BYTE);
  endtask

  task automatic add_body_line();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      add_printable($urandom_range(0, 30));
    end else if (r < 95) begin
      // Lines that start like "From " and then break away.
      n = $urandom_range(0, 4);
      for (int i = 0; i < n; i++) text_stream.push_back(from_text[i]);
      text_stream.push_back(8'($urandom_range(0, 255)));
      add_printable($urandom_range(0, 10));
    end else begin
      // Long tag line: the colon lands around the saturation point of the index.
      repeat ($urandom_range(250, 280)) add_letter();
      text_stream.push_back(mls_pkg::COLON_BYTE);
      text_stream.push_back(mls_pkg::SPACE_BYTE);
    end
    text_stream.push_back(mls_pkg::LF_BYTE);
  endtask

  task automatic add_noise_line();
    repeat ($urandom_range(0, 20)) text_stream.push_back(8'($urandom_range(0, 255)));
    text_stream.push_back(mls_pkg::LF_BYTE);
  endtask

  task automatic run_random_phase(input int budget);
    int unsigned r;
    text_stream.delete();
    while (text_stream.size() < budget) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        add_from_line();
        repeat ($urandom_range(0, 4)) add_tag_line();
        if ($urandom_range(0, 1)) add_tag_line();
        else add_body_line();
        repeat ($urandom_range(0, 3)) add_body_line();
      end else if (r < 85) begin
        add_body_line();
      end else begin
        add_noise_line();
      end
    end
    foreach (text_stream[i]) send_byte(text_stream[i], 1'b0, '0);
  endtask

  initial begin
    logic [7:0] phase_colon [6];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.text_byte = '0;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      for (int i = 0; i < directed_rows[k].text.len(); i++)
        send_byte(directed_rows[k].text[i], 1'b0, '0);
      repeat (directed_rows[k].fill_cnt) send_byte(directed_rows[k].fill, 1'b0, '0);
      send_byte(mls_pkg::LF_BYTE, directed_rows[k].typed, directed_rows[k].want);
    end

    phase_colon = '{8'd4, 8'd0, 8'd255, 8'($urandom_range(0, 255)), 8'd1,
                    8'($urandom_range(0, 255))};
    foreach (phase_colon[p]) begin
      in_ch.valid <= 1'b0;
      set_colon_min(phase_colon[p]);
      no_idle = (p == 3);
      run_random_phase(140);
    end
    in_ch.valid <= 1'b0;
    no_idle = 1'b0;

    drain_lines();
    repeat (10) @(posedge clk);
    $display("Sent %0d text bytes and checked %0d line results under %0d colon settings.",
             n_bytes, n_lines, n_settings);
    $display("Action codes observed (bit per code): %b", actions_seen);
    if (n_fail == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/mls_pkg.sv
rtl/core/mls_in_if.sv
rtl/core/mls_out_if.sv
rtl/core/mls_line_scan.sv
rtl/core/mls_split_fsm.sv
rtl/core/mailbox_line_splitter_unit.sv
rtl/core/mls_checker.sv
sim/mailbox_line_splitter_unit_test.sv
